// ----- rtl/fem1_pkg.sv -----
// Shared constants and helper functions for the exp(x)-1 pipeline.
`default_nettype none
package fem1_pkg;

  localparam logic [31:0] F_MAGIC     = 32'h4A40_0000;
  localparam logic [31:0] F_NEG_MAGIC = 32'hCA40_0000;
  localparam logic [31:0] F_LOG2E     = 32'h3FB8_AA3B;
  localparam logic [30:0] CUTOFF_MAG  = 31'h418A_A123;
  localparam logic [31:0] F_MLN2_HI   = 32'hBF31_7200;
  localparam logic [31:0] F_MLN2_LO   = 32'hB5BF_BE8E;
  localparam logic [31:0] F_C4        = 32'h3D2A_A7CD;
  localparam logic [31:0] F_C3        = 32'h3E2A_B841;
  localparam logic [31:0] F_C2        = 32'h3F00_0001;
  localparam logic [31:0] F_NEG_ONE   = 32'hBF80_0000;
  localparam logic [31:0] F_QNAN      = 32'h7FC0_0000;
  localparam logic [1:0]  TW_IDX_MASK = 2'h3;
  localparam int          TW_COUNT    = 4;

  // Leading zero count of a 48-bit product.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // Leading zero count of a 28-bit sum.
  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    n = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) n = 5'(27 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fem1_fmul.sv -----
// Two-stage binary32 multiplier, round to nearest even, with subnormals.
`default_nettype none
module fem1_fmul
  import fem1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [10:0] e;
    logic        [47:0] prod;
  } mul_s1_t;

  mul_s1_t s1_nxt, s1_r;
  logic    [31:0] y_nxt, y_r;

  logic [7:0] ea, eb;
  logic       a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;

  always_comb begin
    ea     = a[30:23];
    eb     = b[30:23];
    a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
    a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
    a_zero = (ea == 8'h00) && (a[22:0] == 23'd0);
    b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
    b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
    b_zero = (eb == 8'h00) && (b[22:0] == 23'd0);
    s1_nxt.sign = a[31] ^ b[31];
    s1_nxt.nan  = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
    s1_nxt.inf  = a_inf | b_inf;
    s1_nxt.zero = a_zero | b_zero;
    s1_nxt.e    = $signed(11'((ea == 8'h00) ? 8'd1 : ea))
                + $signed(11'((eb == 8'h00) ? 8'd1 : eb)) - 11'sd127;
    s1_nxt.prod = {24'd0, (ea != 8'h00), a[22:0]} * {24'd0, (eb != 8'h00), b[22:0]};
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    y_r  <= y_nxt;
  end

  logic        [5:0]  lz;
  logic signed [10:0] ex, rsw;
  logic        [4:0]  rs;
  logic        [47:0] norm, sh;
  logic               lost, grd, stk, inc, ovf;
  logic        [7:0]  field;
  logic        [30:0] mag;

  always_comb begin
    lz    = lzc48(s1_r.prod);
    norm  = s1_r.prod << lz;
    ex    = s1_r.e + 11'sd1 - $signed({5'd0, lz});
    rsw   = 11'sd1 - ex;
    rs    = 5'd0;
    sh    = norm;
    lost  = 1'b0;
    field = 8'd0;
    ovf   = 1'b0;
    if (ex >= 11'sd1) begin
      ovf   = (ex >= 11'sd255);
      field = ex[7:0];
    end else begin
      rs   = (rsw > 11'sd31) ? 5'd31 : rsw[4:0];
      sh   = norm >> rs;
      lost = |(norm & ((48'd1 << rs) - 48'd1));
    end
    grd = sh[23];
    stk = (|sh[22:0]) | lost;
    inc = grd & (stk | sh[24]);
    mag = {field, sh[46:24]} + {30'd0, inc};
    if (s1_r.nan)                  y_nxt = F_QNAN;
    else if (s1_r.inf || ovf)      y_nxt = {s1_r.sign, 8'hFF, 23'd0};
    else if (s1_r.zero)            y_nxt = {s1_r.sign, 31'd0};
    else                           y_nxt = {s1_r.sign, mag};
  end

  assign y = y_r;

endmodule
`default_nettype wire

// ----- rtl/fem1_fadd.sv -----
// Two-stage binary32 adder, round to nearest even, with subnormals.
`default_nettype none
module fem1_fadd
  import fem1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic        inf_sign;
    logic        zsign;
    logic [7:0]  eb;
    logic [27:0] m;
  } add_s1_t;

  add_s1_t s1_nxt, s1_r;
  logic [31:0] y_nxt, y_r;

  logic [31:0] big, sml;
  logic [7:0]  ea, ebx, eb_eff, es_eff, d;
  logic        a_nan, a_inf, b_nan, b_inf;
  logic [26:0] mb, ms, shd, al;
  logic        lost1;

  always_comb begin
    ea    = a[30:23];
    ebx   = b[30:23];
    a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
    b_nan = (ebx == 8'hFF) && (b[22:0] != 23'd0);
    b_inf = (ebx == 8'hFF) && (b[22:0] == 23'd0);
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb_eff = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
    es_eff = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
    d      = eb_eff - es_eff;
    mb     = {(big[30:23] != 8'h00), big[22:0], 3'b000};
    ms     = {(sml[30:23] != 8'h00), sml[22:0], 3'b000};
    if (d >= 8'd27) begin
      shd   = 27'd0;
      lost1 = |ms;
    end else begin
      shd   = ms >> d[4:0];
      lost1 = |(ms & ((27'd1 << d[4:0]) - 27'd1));
    end
    al = {shd[26:1], shd[0] | lost1};
    s1_nxt.sign     = big[31];
    s1_nxt.nan      = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
    s1_nxt.inf      = a_inf | b_inf;
    s1_nxt.inf_sign = a_inf ? a[31] : b[31];
    s1_nxt.zsign    = a[31] & b[31];
    s1_nxt.eb       = eb_eff;
    if (a[31] == b[31]) s1_nxt.m = {1'b0, mb} + {1'b0, al};
    else                s1_nxt.m = {1'b0, mb} - {1'b0, al};
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    y_r  <= y_nxt;
  end

  logic [4:0]  lz;
  logic [7:0]  k;
  logic [8:0]  ex;
  logic [27:0] norm;
  logic [7:0]  field;
  logic        sub, ovf, grd, stk, inc;
  logic [30:0] mag;

  always_comb begin
    lz    = lzc28(s1_r.m);
    sub   = ({3'd0, lz} > s1_r.eb);
    k     = sub ? s1_r.eb : {3'd0, lz};
    norm  = s1_r.m << k[4:0];
    ex    = {1'b0, s1_r.eb} + 9'd1 - {1'b0, k};
    field = sub ? 8'd0 : ex[7:0];
    ovf   = !sub && (ex >= 9'd255);
    grd   = norm[3];
    stk   = |norm[2:0];
    inc   = grd & (stk | norm[4]);
    mag   = {field, norm[26:4]} + {30'd0, inc};
    if (s1_r.nan)              y_nxt = F_QNAN;
    else if (s1_r.inf)         y_nxt = {s1_r.inf_sign, 8'hFF, 23'd0};
    else if (s1_r.m == 28'd0)  y_nxt = {s1_r.zsign, 31'd0};
    else if (ovf)              y_nxt = {s1_r.sign, 8'hFF, 23'd0};
    else                       y_nxt = {s1_r.sign, mag};
  end

  assign y = y_r;

endmodule
`default_nettype wire

// ----- rtl/float_expm1_negative_core.sv -----
// Top level of the pipelined single-precision exp(x)-1 core.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+----------------------------
//   input    | start, busy, in_x_bits, in_last_in      | beat taken when start & !busy
//   result   | out_valid, out_result_bits, out_last_out | one-cycle strobe, no backpressure
//   config   | cfg_we, cfg_index, cfg_data             | write on cfg_we, no wait
//
// A beat may enter in every clock cycle; busy is never raised.
// The pipeline depth is set by the chain of fourteen dependent float operations,
// each a two-stage unit.
// Reset (synchronous, active low) clears the valid bits and reloads the table words.
// Nothing stalls: the receiver must take each result in the cycle it is strobed.
`default_nettype none
module float_expm1_negative_core
  import fem1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_x_bits,
  input  wire logic        in_last_in,
  output logic             out_valid,
  output logic      [31:0] out_result_bits,
  output logic             out_last_out,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // The pipeline never holds off a beat, so the core is always ready.
  assign busy = 1'b0;

  // Table words: 2^(k/4) with the exponent pre-adjusted for the scale add.
  logic [31:0] tw_r [TW_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r[0] <= 32'h3F80_0000;
      tw_r[1] <= 32'h3F78_37F0;
      tw_r[2] <= 32'h3F75_04F3;
      tw_r[3] <= 32'h3F77_44FD;
    end else if (cfg_we && (cfg_index < 3'(TW_COUNT))) begin
      tw_r[cfg_index[1:0]] <= cfg_data;
    end
  end

  // Input capture. The valid bit and last flag ride a shift line alongside the data.
  logic [31:0] x_r;
  logic        last_r;
  logic        v_r;
  logic        v_d_r    [28];
  logic        last_d_r [28];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      for (int i = 0; i < 28; i++) v_d_r[i] <= 1'b0;
    end else begin
      v_r      <= start & ~busy;
      v_d_r[0] <= v_r;
      for (int i = 1; i < 28; i++) v_d_r[i] <= v_d_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= in_x_bits;
    last_r      <= in_last_in;
    last_d_r[0] <= last_r;
    for (int i = 1; i < 28; i++) last_d_r[i] <= last_d_r[i-1];
  end

  // Saturation test: x <= cutoff, which is false for any NaN input.
  logic cut;
  assign cut = x_r[31] && (x_r[30:0] >= CUTOFF_MAG) &&
               !((x_r[30:23] == 8'hFF) && (x_r[22:0] != 23'd0));

  // Range reduction: n = round(x*log2e) to a quarter by the magic bias.
  logic [31:0] n1, n2, n3, t1, t2, t3, t;
  logic [31:0] s_nxt;

  fem1_fmul u_n1 (.clk(clk), .a(x_r), .b(F_LOG2E),     .y(n1));
  fem1_fadd u_n2 (.clk(clk), .a(n1),  .b(F_MAGIC),     .y(n2));
  fem1_fadd u_n3 (.clk(clk), .a(n2),  .b(F_NEG_MAGIC), .y(n3));

  // The scale word: table entry from the low two bits, plus a wrapping
  // exponent shift from the rest of the biased word.
  assign s_nxt = tw_r[n2[1:0] & TW_IDX_MASK] + (n2 << 21);

  fem1_fmul u_t1 (.clk(clk), .a(n3), .b(F_MLN2_HI), .y(t1));
  fem1_fmul u_t3 (.clk(clk), .a(n3), .b(F_MLN2_LO), .y(t3));

  logic [31:0] x_d_r   [8];
  logic        cut_d_r [12];
  logic [31:0] s_d_r   [8];
  logic [31:0] t3_d_r  [2];

  always_ff @(posedge clk) begin
    x_d_r[0]   <= x_r;
    cut_d_r[0] <= cut;
    s_d_r[0]   <= s_nxt;
    t3_d_r[0]  <= t3;
    t3_d_r[1]  <= t3_d_r[0];
    for (int i = 1; i < 8; i++) begin
      x_d_r[i] <= x_d_r[i-1];
      s_d_r[i] <= s_d_r[i-1];
    end
    for (int i = 1; i < 12; i++) cut_d_r[i] <= cut_d_r[i-1];
  end

  fem1_fadd u_t2 (.clk(clk), .a(t1),        .b(x_d_r[7]), .y(t2));
  fem1_fadd u_t  (.clk(clk), .a(t3_d_r[1]), .b(t2),       .y(t));

  // Deep negative inputs force both the scale and the reduced argument to +0.
  logic [31:0] t_f, s_f;
  assign t_f = cut_d_r[11] ? 32'd0 : t;
  assign s_f = cut_d_r[11] ? 32'd0 : s_d_r[7];

  logic [31:0] p1, p2, p3, p4, p5, ts, sm1, q, r, f;
  logic [31:0] t_d_r   [8];
  logic [31:0] ts_d_r  [10];
  logic [31:0] sm1_d_r [12];

  fem1_fmul u_p1  (.clk(clk), .a(F_C4), .b(t_f),       .y(p1));
  fem1_fmul u_ts  (.clk(clk), .a(t_f),  .b(s_f),       .y(ts));
  fem1_fadd u_sm1 (.clk(clk), .a(s_f),  .b(F_NEG_ONE), .y(sm1));

  always_ff @(posedge clk) begin
    t_d_r[0]   <= t_f;
    ts_d_r[0]  <= ts;
    sm1_d_r[0] <= sm1;
    for (int i = 1; i < 8; i++)  t_d_r[i]   <= t_d_r[i-1];
    for (int i = 1; i < 10; i++) ts_d_r[i]  <= ts_d_r[i-1];
    for (int i = 1; i < 12; i++) sm1_d_r[i] <= sm1_d_r[i-1];
  end

  // Polynomial in Horner form, then the rebuild (t*s) + (t*s)*p + (s-1).
  fem1_fadd u_p2 (.clk(clk), .a(p1), .b(F_C3),        .y(p2));
  fem1_fmul u_p3 (.clk(clk), .a(p2), .b(t_d_r[3]),    .y(p3));
  fem1_fadd u_p4 (.clk(clk), .a(p3), .b(F_C2),        .y(p4));
  fem1_fmul u_p5 (.clk(clk), .a(p4), .b(t_d_r[7]),    .y(p5));
  fem1_fmul u_q  (.clk(clk), .a(p5), .b(ts_d_r[7]),   .y(q));
  fem1_fadd u_r  (.clk(clk), .a(q),  .b(ts_d_r[9]),   .y(r));
  fem1_fadd u_f  (.clk(clk), .a(r),  .b(sm1_d_r[11]), .y(f));

  // Output register; every NaN leaves as the canonical quiet NaN.
  logic        out_valid_r;
  logic [31:0] out_result_bits_r, out_result_bits_nxt;
  logic        out_last_out_r;

  assign out_result_bits_nxt =
    ((f[30:23] == 8'hFF) && (f[22:0] != 23'd0)) ? F_QNAN : f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_d_r[27];
    end
  end

  always_ff @(posedge clk) begin
    out_result_bits_r <= out_result_bits_nxt;
    out_last_out_r    <= last_d_r[27];
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_result_bits_r;
  assign out_last_out    = out_last_out_r;

endmodule
`default_nettype wire
